// ===== rtl/joystick_calibrate_and_direction_core_assert.svh =====
// assertion macros used by the checker file
`ifndef JOYSTICK_CALIBRATE_AND_DIRECTION_CORE_ASSERT_SVH
`define JOYSTICK_CALIBRATE_AND_DIRECTION_CORE_ASSERT_SVH

// implication in the same cycle, quiet during reset
`define JCD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, quiet during reset
`define JCD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication into the next cycle, also checked while reset is high
`define JCD_ASSERT_NXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jcd_pkg.sv =====
// shared types, constants and codes of the joystick calibration core
`timescale 1ns / 1ps

package jcd_pkg;

   localparam int NUM_W     = 15;  // |diff| * 100 fits in 15 bits
   localparam int DEN_W     = 8;
   localparam int QUOT_BITS = 7;   // quotient bits needed below saturation
   localparam int CNT_W     = $clog2(QUOT_BITS);

   localparam logic [6:0] PCT_FULL        = 7'd100;
   localparam logic [6:0] DEAD_ZONE_RESET = 7'd5;
   localparam logic [7:0] SAMPLE_TOP      = 8'd255;

   localparam logic MODE_CALIBRATE = 1'b0;
   localparam logic MODE_READ      = 1'b1;

   typedef enum logic [2:0] {
      HEAD_NEUTRAL = 3'd0,
      HEAD_UP      = 3'd1,
      HEAD_DOWN    = 3'd2,
      HEAD_LEFT    = 3'd3,
      HEAD_RIGHT   = 3'd4
   } heading_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] x_sample;
      logic [7:0] y_sample;
   } req_item_type;

   typedef struct packed {
      logic signed [7:0] x_percent;
      logic signed [7:0] y_percent;
      heading_type       heading;
   } rsp_item_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             zero;
   } axis_work_type;

   typedef struct packed {
      logic          mode;
      axis_work_type x_axis;
      axis_work_type y_axis;
   } work_entry_type;

endpackage

// ===== rtl/jcd_front.sv =====
// front end: accepts samples, tracks calibration, prepares division operands
`timescale 1ns / 1ps

module jcd_front
   import jcd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  req_item_type   req_item,
   input  logic           q_full,
   output logic           q_wr_en,
   output work_entry_type q_wr_data
);

   logic [7:0] x_low_ff, x_high_ff, x_centre_ff;
   logic [7:0] x_low_in, x_high_in, x_centre_in;
   logic       x_known_ff, x_known_in;
   logic [7:0] y_low_ff, y_high_ff, y_centre_ff;
   logic [7:0] y_low_in, y_high_in, y_centre_in;
   logic       y_known_ff, y_known_in;
   logic       accept;

   function automatic axis_work_type axis_work(input logic [7:0] s, input logic [7:0] lo,
                                               input logic [7:0] hi, input logic [7:0] ctr);
      logic signed [8:0] diff;
      logic signed [8:0] span;
      logic [7:0]        adiff;
      logic [7:0]        aspan;
      axis_work_type     w;
      diff = $signed({1'b0, s}) - $signed({1'b0, ctr});
      if (s <= ctr) begin
         span = $signed({1'b0, ctr}) - $signed({1'b0, lo});
      end else begin
         span = $signed({1'b0, hi}) - $signed({1'b0, ctr});
      end
      adiff  = diff[8] ? 8'(-diff) : diff[7:0];
      aspan  = span[8] ? 8'(-span) : span[7:0];
      w.num  = NUM_W'(adiff) * NUM_W'(PCT_FULL);
      w.den  = aspan;
      w.neg  = diff[8] ^ span[8];
      w.zero = (span == 9'sd0);
      return w;
   endfunction

   assign accept  = push && !q_full;
   assign q_wr_en = accept;

   always_comb begin
      q_wr_data.mode   = req_item.mode;
      q_wr_data.x_axis = axis_work(req_item.x_sample, x_low_ff, x_high_ff, x_centre_ff);
      q_wr_data.y_axis = axis_work(req_item.y_sample, y_low_ff, y_high_ff, y_centre_ff);
   end

   always_comb begin
      x_low_in    = x_low_ff;
      x_high_in   = x_high_ff;
      x_centre_in = x_centre_ff;
      x_known_in  = x_known_ff;
      y_low_in    = y_low_ff;
      y_high_in   = y_high_ff;
      y_centre_in = y_centre_ff;
      y_known_in  = y_known_ff;
      if (accept && req_item.mode == MODE_CALIBRATE) begin
         if (!x_known_ff) begin
            x_centre_in = req_item.x_sample;
            x_known_in  = 1'b1;
         end
         if (req_item.x_sample > x_high_ff) x_high_in = req_item.x_sample;
         if (req_item.x_sample < x_low_ff)  x_low_in  = req_item.x_sample;
         if (!y_known_ff) begin
            y_centre_in = req_item.y_sample;
            y_known_in  = 1'b1;
         end
         if (req_item.y_sample > y_high_ff) y_high_in = req_item.y_sample;
         if (req_item.y_sample < y_low_ff)  y_low_in  = req_item.y_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff    <= SAMPLE_TOP;
         x_high_ff   <= '0;
         x_centre_ff <= '0;
         x_known_ff  <= 1'b0;
         y_low_ff    <= SAMPLE_TOP;
         y_high_ff   <= '0;
         y_centre_ff <= '0;
         y_known_ff  <= 1'b0;
      end else begin
         x_low_ff    <= x_low_in;
         x_high_ff   <= x_high_in;
         x_centre_ff <= x_centre_in;
         x_known_ff  <= x_known_in;
         y_low_ff    <= y_low_in;
         y_high_ff   <= y_high_in;
         y_centre_ff <= y_centre_in;
         y_known_ff  <= y_known_in;
      end
   end

endmodule

// ===== rtl/jcd_queue.sv =====
// short queue between front and back end
`timescale 1ns / 1ps

module jcd_queue
   import jcd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  work_entry_type wr_data,
   output logic           full,
   input  logic           rd_en,
   output work_entry_type rd_data,
   output logic           empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_entry_type   slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_wr) slots_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/jcd_divider.sv =====
// restoring divider for one axis, one quotient bit per step, saturating at 100
`timescale 1ns / 1ps

module jcd_divider
   import jcd_pkg::*;
(
   input  logic              clock,
   input  logic              start,
   input  logic              step,
   input  axis_work_type     work,
   output logic [6:0]        magnitude,
   output logic signed [7:0] percent
);

   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     dv_ff, dv_in;
   logic [QUOT_BITS-1:0] q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [7:0]           mag_ext;

   always_comb begin
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         rem_in  = work.num;
         dv_in   = NUM_W'(work.den) << (QUOT_BITS - 1);
         q_in    = '0;
         // quotient would need more bits than we keep: saturates anyway
         ovf_in  = work.num >= (NUM_W'(work.den) << QUOT_BITS);
         neg_in  = work.neg;
         zero_in = work.zero;
      end else if (step) begin
         if (rem_ff >= dv_ff) begin
            rem_in = rem_ff - dv_ff;
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         dv_in = dv_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) magnitude = '0;
      else if (ovf_ff || q_ff > PCT_FULL) magnitude = PCT_FULL;
      else magnitude = q_ff;
      mag_ext = {1'b0, magnitude};
      percent = neg_ff ? $signed(~mag_ext + 8'd1) : $signed(mag_ext);
   end

endmodule

// ===== rtl/jcd_back.sv =====
// back end: runs both axis divisions, classifies heading, holds the result
`timescale 1ns / 1ps

module jcd_back
   import jcd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  work_entry_type q_rd_data,
   output logic           q_rd_en,
   input  logic [6:0]     dead_zone,
   output logic           empty,
   input  logic           pop,
   output rsp_item_type   rsp_item
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              mode_ff;
   logic              out_valid_ff;
   rsp_item_type      rsp_ff;
   rsp_item_type      rsp_next;
   logic              start, step;
   logic              rsp_load;
   logic [6:0]        x_mag, y_mag;
   logic signed [7:0] x_pct, y_pct;

   assign start    = (state_ff == S_IDLE) && !q_empty;
   assign step     = (state_ff == S_DIV);
   assign q_rd_en  = start;
   assign rsp_load = (state_ff == S_DONE) && (!out_valid_ff || pop);

   jcd_divider u_div_x (
      .clock     (clock),
      .start     (start),
      .step      (step),
      .work      (q_rd_data.x_axis),
      .magnitude (x_mag),
      .percent   (x_pct)
   );

   jcd_divider u_div_y (
      .clock     (clock),
      .start     (start),
      .step      (step),
      .work      (q_rd_data.y_axis),
      .magnitude (y_mag),
      .percent   (y_pct)
   );

   always_comb begin
      rsp_next.x_percent = '0;
      rsp_next.y_percent = '0;
      rsp_next.heading   = HEAD_NEUTRAL;
      if (mode_ff == MODE_READ) begin
         rsp_next.x_percent = x_pct;
         rsp_next.y_percent = y_pct;
         if (x_mag < dead_zone && y_mag < dead_zone) rsp_next.heading = HEAD_NEUTRAL;
         else if (x_mag < y_mag) rsp_next.heading = y_pct[7] ? HEAD_DOWN : HEAD_UP;
         else rsp_next.heading = x_pct[7] ? HEAD_LEFT : HEAD_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) out_valid_ff <= 1'b1;
         else if (pop) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  mode_ff  <= q_rd_data.mode;
                  cnt_ff   <= CNT_W'(QUOT_BITS - 1);
                  state_ff <= (q_rd_data.mode == MODE_CALIBRATE) ? S_DONE : S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == '0) state_ff <= S_DONE;
               else cnt_ff <= cnt_ff - 1'b1;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_ff   <= rsp_next;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

// ===== rtl/joystick_calibrate_and_direction_core.sv =====
// joystick calibration and direction core: top level with register port
`timescale 1ns / 1ps
// a read item runs the seven steps of the per-axis restoring divider in the back end,
// a calibrate item skips them; the back end takes a new item only once the last result
//   is loaded into the result register
// the front takes new items while the queue has room, so bursts up to the queue depth pass
// reset (synchronous): calibration cleared, queue and result emptied, dead zone back to 5

module joystick_calibrate_and_direction_core
   import jcd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   // input side
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   // result side
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   // register port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam logic [1:0] ADDR_DEAD_ZONE = 2'd0;

   logic [6:0]     dead_zone_ff;
   logic           csr_write;
   logic           q_wr_en, q_rd_en, q_full, q_empty;
   work_entry_type q_wr_data, q_rd_data;

   // register port: no wait states, dead zone is the only register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == ADDR_DEAD_ZONE);
   assign prdata    = (paddr == ADDR_DEAD_ZONE) ? {25'd0, dead_zone_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RESET;
      end else if (csr_write) begin
         dead_zone_ff <= pwdata[6:0];
      end
   end

   // input side stalls only when the queue is full
   assign full = q_full;

   // front: calibration tracking and operand preparation at transfer time
   jcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_wr_en   (q_wr_en),
      .q_wr_data (q_wr_data)
   );

   // decoupling queue: operands already carry the calibration seen by each item
   jcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // back: divisions, saturation, heading and the result register
   jcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rd_data (q_rd_data),
      .q_rd_en   (q_rd_en),
      .dead_zone (dead_zone_ff),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/jcd_checker.sv =====
// port-level checks of the joystick core and their binding
`timescale 1ns / 1ps
`include "joystick_calibrate_and_direction_core_assert.svh"

module jcd_checker
   import jcd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         empty,
   input logic         pop,
   input rsp_item_type rsp_item
);

   `JCD_ASSERT_NXT_ALWAYS(a_reset_empty, reset, empty, "result side not empty after reset")
   `JCD_ASSERT_NXT(a_rsp_hold, (!empty && !pop), (!empty && $stable(rsp_item)), "result changed while stalled")
   `JCD_ASSERT_IMP(a_pct_range, !empty, ((rsp_item.x_percent >= -8'sd100) && (rsp_item.x_percent <= 8'sd100) && (rsp_item.y_percent >= -8'sd100) && (rsp_item.y_percent <= 8'sd100)), "percent out of range")
   `JCD_ASSERT_IMP(a_up_positive, (!empty && rsp_item.heading == HEAD_UP), (rsp_item.y_percent > 8'sd0), "up heading without positive vertical percent")

endmodule

bind joystick_calibrate_and_direction_core jcd_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
